>>> rtl/msseq_pkg.sv
// Shared types and constants for the motor servo sequencer.
package msseq_pkg;

  localparam int unsigned TIMER_BITS = 16;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam int unsigned APB_DW     = 32;
  localparam int unsigned APB_AW     = 4;

  localparam logic [2:0] ST_STOP        = 3'd0;
  localparam logic [2:0] ST_RUN         = 3'd1;
  localparam logic [2:0] ST_SERVO_OFF   = 3'd2;
  localparam logic [2:0] ST_SERVO_ON    = 3'd3;
  localparam logic [2:0] ST_RESET       = 3'd4;
  localparam logic [2:0] ST_RESET_CHECK = 3'd5;

  localparam logic [1:0] DRV_STOP = 2'd0;
  localparam logic [1:0] DRV_FWD  = 2'd1;
  localparam logic [1:0] DRV_REV  = 2'd2;

  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_RESET = 2'd2;

  localparam logic [1:0] REG_SETTLE  = 2'd0;
  localparam logic [1:0] REG_PULSE   = 2'd1;
  localparam logic [1:0] REG_RECHECK = 2'd2;

  localparam logic [CFG_W-1:0] SETTLE_RST  = CFG_W'(500);
  localparam logic [CFG_W-1:0] PULSE_RST   = CFG_W'(50);
  localparam logic [CFG_W-1:0] RECHECK_RST = CFG_W'(500);

  typedef struct packed {
    logic [CFG_W-1:0] settle_ticks;
    logic [CFG_W-1:0] pulse_ticks;
    logic [CFG_W-1:0] recheck_ticks;
  } cfg_t;

endpackage

>>> rtl/msseq_in_if.sv
// Request channel carrying one tick of command and switch levels.
interface msseq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       reset_switch;
  logic       stop_switch;

  modport source (output valid, command, reset_switch, stop_switch, input ready);
  modport sink (input valid, command, reset_switch, stop_switch, output ready);
endinterface

>>> rtl/msseq_out_if.sv
// Result channel carrying the drive, servo level and sequencer state.
interface msseq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] motor_drive;
  logic       servo_open;
  logic [2:0] sequencer_state;

  modport source (output valid, motor_drive, servo_open, sequencer_state, input ready);
  modport sink (input valid, motor_drive, servo_open, sequencer_state, output ready);
endinterface

>>> rtl/msseq_regs.sv
// APB configuration registers for the motor servo sequencer.
module msseq_regs
  import msseq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t        cfg_q;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ticks  <= SETTLE_RST;
      cfg_q.pulse_ticks   <= PULSE_RST;
      cfg_q.recheck_ticks <= RECHECK_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SETTLE:  cfg_q.settle_ticks  <= pwdata[CFG_W-1:0];
        REG_PULSE:   cfg_q.pulse_ticks   <= pwdata[CFG_W-1:0];
        REG_RECHECK: cfg_q.recheck_ticks <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SETTLE:  prdata = APB_DW'(cfg_q.settle_ticks);
      REG_PULSE:   prdata = APB_DW'(cfg_q.pulse_ticks);
      REG_RECHECK: prdata = APB_DW'(cfg_q.recheck_ticks);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/motor_servo_sequencer_core.sv
// Top level of the motor servo sequencer: tick-driven state machine and result register.
//
// Each request on req_i is one 1 ms tick carrying the command (none, run, reset)
// and the reset and stop switch levels. Every request produces exactly one result
// on rsp_o with the motor drive, the servo level and the sequencer state after
// that tick's update.
// The sequencer state is updated at the edge that accepts a request. The result
// is held in the output register from that same edge, so it can be taken in the
// following cycle.
// A new request is accepted every cycle while the output register is empty or
// is being taken in the same cycle, so the sustained rate is one tick per cycle.
// When the receiver stalls, the result is held and req_i.ready drops until it
// is taken.
// The APB port sets the settle, drive pulse and recheck times in ticks. It is to
// be written only while no request is in flight; the block does not enforce this.
// Reset returns the sequencer to stop with the drive stopped, the servo closed,
// all pending flags and counters cleared, and the registers at their defaults.
module motor_servo_sequencer_core
  import msseq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  msseq_in_if.sink          req_i,
  msseq_out_if.source       rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_STOP,
    ACT_RUN,
    ACT_SERVO_OFF,
    ACT_SERVO_ON,
    ACT_REVERSE,
    ACT_CHECK
  } act_e;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  cfg_t cfg;

  logic [2:0]            state_q, state_d;
  logic                  run_pend_q, run_pend_d;
  logic                  rst_pend_q, rst_pend_d;
  logic                  needs_open_q, needs_open_d;
  logic                  armed_q, armed_d;
  logic [TIMER_BITS-1:0] elapsed_q, elapsed_d;
  logic [CFG_W-1:0]      recheck_q, recheck_d;
  logic [1:0]            drive_q, drive_d;
  logic                  servo_q, servo_d;
  logic                  out_valid_q;

  act_e                  act;
  logic                  set_run, set_rst, clr_rst, arm;
  logic [TIMER_BITS-1:0] elapsed_inc;
  logic [CFG_W-1:0]      recheck_nxt;
  logic                  armed_now;
  logic                  accept;

  msseq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign elapsed_inc = (elapsed_q == TIMER_MAX) ? elapsed_q : elapsed_q + 1'b1;

  // Pick this tick's action from the current state and inputs.
  always_comb begin
    act         = ACT_NONE;
    set_run     = 1'b0;
    set_rst     = 1'b0;
    clr_rst     = 1'b0;
    arm         = 1'b0;
    recheck_nxt = recheck_q;
    unique case (state_q)
      ST_STOP: begin
        if (rst_pend_q) begin
          if (recheck_q < cfg.recheck_ticks) begin
            recheck_nxt = recheck_q + 1'b1;
          end else begin
            recheck_nxt = '0;
            if (req_i.reset_switch) begin
              clr_rst = 1'b1;
              act     = ACT_STOP;
            end else begin
              act = ACT_SERVO_ON;
            end
          end
        end else if (req_i.command == CMD_RUN) begin
          set_run = 1'b1;
          act     = ACT_SERVO_ON;
        end else if (req_i.command == CMD_RESET && !req_i.reset_switch) begin
          set_rst = 1'b1;
          act     = ACT_SERVO_ON;
        end else begin
          act = ACT_STOP;
        end
      end
      ST_RUN: begin
        act = (CMP_W'(elapsed_inc) >= CMP_W'(cfg.pulse_ticks)) ? ACT_SERVO_OFF : ACT_RUN;
      end
      ST_SERVO_OFF: begin
        if (req_i.reset_switch && rst_pend_q) begin
          act = ACT_CHECK;
        end else if (req_i.stop_switch) begin
          act = ACT_STOP;
        end else begin
          act = ACT_SERVO_OFF;
        end
      end
      ST_SERVO_ON: begin
        if (CMP_W'(elapsed_inc) >= CMP_W'(cfg.settle_ticks)) begin
          if (req_i.reset_switch || req_i.stop_switch) begin
            act = ACT_SERVO_ON;
          end else if (rst_pend_q) begin
            arm = 1'b1;
            act = ACT_REVERSE;
          end else if (run_pend_q) begin
            arm = 1'b1;
            act = ACT_RUN;
          end else begin
            act = ACT_SERVO_ON;
          end
        end
      end
      ST_RESET: begin
        act = (CMP_W'(elapsed_inc) >= CMP_W'(cfg.pulse_ticks)) ? ACT_SERVO_OFF : ACT_REVERSE;
      end
      ST_RESET_CHECK: act = ACT_STOP;
      default: ;
    endcase
  end

  // Apply the chosen action to the sequencer state.
  always_comb begin
    armed_now    = armed_q || arm;
    state_d      = state_q;
    run_pend_d   = run_pend_q || set_run;
    rst_pend_d   = (rst_pend_q || set_rst) && !clr_rst;
    needs_open_d = needs_open_q;
    armed_d      = armed_now;
    elapsed_d    = elapsed_inc;
    recheck_d    = recheck_nxt;
    drive_d      = drive_q;
    servo_d      = servo_q;
    unique case (act)
      ACT_STOP: begin
        state_d      = ST_STOP;
        drive_d      = DRV_STOP;
        run_pend_d   = 1'b0;
        needs_open_d = 1'b1;
        armed_d      = 1'b1;
      end
      ACT_RUN: begin
        state_d = ST_RUN;
        drive_d = DRV_FWD;
        if (armed_now) begin
          armed_d   = 1'b0;
          elapsed_d = '0;
        end
      end
      ACT_SERVO_OFF: begin
        state_d = ST_SERVO_OFF;
        if (!needs_open_q) begin
          needs_open_d = 1'b1;
          servo_d      = 1'b0;
        end
      end
      ACT_SERVO_ON: begin
        state_d = ST_SERVO_ON;
        if (needs_open_q) begin
          needs_open_d = 1'b0;
          servo_d      = 1'b1;
        end
        if (armed_now) begin
          armed_d   = 1'b0;
          elapsed_d = '0;
        end
      end
      ACT_REVERSE: begin
        state_d = ST_RESET;
        drive_d = DRV_REV;
        if (armed_now) begin
          armed_d   = 1'b0;
          elapsed_d = '0;
        end
      end
      ACT_CHECK: begin
        state_d    = ST_RESET_CHECK;
        drive_d    = DRV_STOP;
        rst_pend_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_STOP;
      run_pend_q   <= 1'b0;
      rst_pend_q   <= 1'b0;
      needs_open_q <= 1'b0;
      armed_q      <= 1'b0;
      elapsed_q    <= '0;
      recheck_q    <= '0;
      drive_q      <= DRV_STOP;
      servo_q      <= 1'b0;
    end else if (accept) begin
      state_q      <= state_d;
      run_pend_q   <= run_pend_d;
      rst_pend_q   <= rst_pend_d;
      needs_open_q <= needs_open_d;
      armed_q      <= armed_d;
      elapsed_q    <= elapsed_d;
      recheck_q    <= recheck_d;
      drive_q      <= drive_d;
      servo_q      <= servo_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.motor_drive     = drive_q;
  assign rsp_o.servo_open      = servo_q;
  assign rsp_o.sequencer_state = state_q;

`ifndef SYNTHESIS
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_o.valid)
    else $error("Accepted request did not produce a result.");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |-> !req_i.ready)
    else $error("Request accepted while a result was stalled.");

  a_recheck_only_in_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (recheck_q != '0) |-> (state_q == ST_STOP && rst_pend_q))
    else $error("Recheck wait running outside a pending reset in stop.");
`endif

endmodule
